[hw/rtl/feature_bucket_limiter_top_assert.svh]
// assertion macros shared by the checker of the feature bucket limiter
// needs a clk and an rst_n signal in the scope where a macro is used
`ifndef FEATURE_BUCKET_LIMITER_TOP_ASSERT_SVH
`define FEATURE_BUCKET_LIMITER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FBL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbl assertion failed");

// next-cycle implication, disabled during reset
`define FBL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbl assertion failed");

`endif

[hw/rtl/fbl_pkg.sv]
// shared types, constants and codes of the feature bucket limiter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbl_pkg;

    localparam int MAX_BUCKETS = 256;
    localparam int ADDR_W      = $clog2(MAX_BUCKETS);

    localparam int COORD_W = 18;
    localparam int SIZE_W  = 13;
    localparam int GRID_W  = 5;
    localparam int COUNT_W = 16;
    localparam int INDEX_W = 16;
    localparam int ID_W    = 9;
    localparam int CELL_W  = 4;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // limit is size times 16, product is coordinate times grid size
    localparam int LIMIT_W = SIZE_W + 4;
    localparam int PROD_W  = LIMIT_W + GRID_W;
    localparam int DIVR_W  = LIMIT_W + CELL_W - 1;

    localparam int DIV_STEPS = CELL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKETS_ACROSS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKETS_DOWN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_BUCKET = 3'd4;

    // reset values
    localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [GRID_W-1:0]  RST_BUCKETS      = 5'd8;
    localparam logic [COUNT_W-1:0] RST_MAX_PER_BKT  = 16'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_LOOKUP,
        ST_COMMIT
    } fbl_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic lookup;
        logic commit;
    } fbl_cmd_t;

    typedef struct packed {
        logic out_free;
    } fbl_sts_t;

endpackage

`default_nettype wire

[hw/rtl/fbl_ctrl.sv]
// sequencing state machine of the feature bucket limiter
// depends on fbl_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbl_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  fbl_pkg::fbl_sts_t sts,
    output fbl_pkg::fbl_cmd_t cmd
);
    import fbl_pkg::*;

    fbl_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/fbl_datapath.sv]
// datapath of the feature bucket limiter: config registers, bounds check,
// restoring cell divider, bucket count memory and output register
// depends on fbl_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbl_datapath (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [fbl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [fbl_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire  [fbl_pkg::COORD_W-1:0]   in_x,
    input  wire  [fbl_pkg::COORD_W-1:0]   in_y,
    input  wire                          in_frame_start,
    input  fbl_pkg::fbl_cmd_t             cmd,
    output fbl_pkg::fbl_sts_t             sts,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [fbl_pkg::INDEX_W-1:0]   out_point_index,
    output logic [fbl_pkg::ID_W-1:0]      out_bucket_id,
    output logic                         out_in_image,
    output logic                         out_selected
);
    import fbl_pkg::*;

    function automatic logic [GRID_W-1:0] grid_dim(input logic [GRID_W-1:0] v);
        logic [GRID_W-1:0] r;
        if (v == '0)
            r = GRID_W'(1);
        else if (v > GRID_W'(16))
            r = GRID_W'(16);
        else
            r = v;
        return r;
    endfunction

    // configuration
    logic [SIZE_W-1:0]  width_reg, height_reg;
    logic [GRID_W-1:0]  across_reg, down_reg;
    logic [COUNT_W-1:0] max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            across_reg <= RST_BUCKETS;
            down_reg   <= RST_BUCKETS;
            max_reg    <= RST_MAX_PER_BKT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:    width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_BUCKETS_ACROSS: across_reg <= cfg_wdata[GRID_W-1:0];
                REG_BUCKETS_DOWN:   down_reg   <= cfg_wdata[GRID_W-1:0];
                REG_MAX_PER_BUCKET: max_reg    <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [GRID_W-1:0] bh, bv;
    assign bh = grid_dim(across_reg);
    assign bv = grid_dim(down_reg);

    // point index counter
    logic [INDEX_W-1:0] next_idx_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [COORD_W-1:0] x_reg, y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            next_idx_reg <= '0;
        else if (cmd.load)
            next_idx_reg <= (in_frame_start ? '0 : next_idx_reg) + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= in_frame_start ? '0 : next_idx_reg;
            x_reg   <= in_x;
            y_reg   <= in_y;
        end
    end

    // bounds check and divider set-up
    logic [LIMIT_W-1:0] lim_x, lim_y;
    logic               inside_x, inside_y;
    assign lim_x    = {width_reg, 4'b0000};
    assign lim_y    = {height_reg, 4'b0000};
    assign inside_x = !x_reg[COORD_W-1] && (lim_x != '0) && (x_reg[LIMIT_W-1:0] < lim_x);
    assign inside_y = !y_reg[COORD_W-1] && (lim_y != '0) && (y_reg[LIMIT_W-1:0] < lim_y);

    logic               inside_reg;
    logic [PROD_W-1:0]  rem_x_reg, rem_y_reg;
    logic [DIVR_W-1:0]  dvr_x_reg, dvr_y_reg;
    logic [CELL_W-1:0]  col_reg, row_reg;
    logic               ge_x, ge_y;

    assign ge_x = rem_x_reg >= PROD_W'(dvr_x_reg);
    assign ge_y = rem_y_reg >= PROD_W'(dvr_y_reg);

    // one quotient bit per step on each axis
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            inside_reg <= inside_x && inside_y;
            rem_x_reg  <= PROD_W'(x_reg[LIMIT_W-1:0]) * PROD_W'(bh);
            rem_y_reg  <= PROD_W'(y_reg[LIMIT_W-1:0]) * PROD_W'(bv);
            dvr_x_reg  <= {lim_x, (CELL_W-1)'(0)};
            dvr_y_reg  <= {lim_y, (CELL_W-1)'(0)};
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (ge_x)
                rem_x_reg <= rem_x_reg - PROD_W'(dvr_x_reg);
            if (ge_y)
                rem_y_reg <= rem_y_reg - PROD_W'(dvr_y_reg);
            col_reg   <= {col_reg[CELL_W-2:0], ge_x};
            row_reg   <= {row_reg[CELL_W-2:0], ge_y};
            dvr_x_reg <= dvr_x_reg >> 1;
            dvr_y_reg <= dvr_y_reg >> 1;
        end
    end

    // bucket id and count lookup
    logic [ID_W-1:0]   id_calc;
    logic [ID_W-1:0]   id_reg;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              in_range_reg;

    assign id_calc = inside_reg ? (ID_W'(row_reg) * ID_W'(bh) + ID_W'(col_reg))
                                : (ID_W'(bh) * ID_W'(bv));
    assign rd_addr = ADDR_W'(id_calc);
    assign wr_addr = ADDR_W'(id_reg);

    logic [COUNT_W-1:0] mem [MAX_BUCKETS];
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic               vld_rd_reg;
    logic               vld_reg [MAX_BUCKETS];

    logic [COUNT_W-1:0] count;
    logic               sel;
    assign count = vld_rd_reg ? cnt_rd_reg : '0;
    assign sel   = inside_reg && in_range_reg && (count < max_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            id_reg       <= id_calc;
            in_range_reg <= 32'(id_calc) < MAX_BUCKETS;
            cnt_rd_reg   <= mem[rd_addr];
            vld_rd_reg   <= vld_reg[rd_addr];
        end
        if (cmd.commit && sel)
            mem[wr_addr] <= count + 1'b1;
    end

    // entry valid bits, all dropped at frame start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BUCKETS; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (cmd.load && in_frame_start)
        begin
            for (int i = 0; i < MAX_BUCKETS; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (cmd.commit && sel)
            vld_reg[wr_addr] <= 1'b1;
    end

    // output register
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_point_index <= idx_reg;
            out_bucket_id   <= id_reg;
            out_in_image    <= inside_reg;
            out_selected    <= sel;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

[hw/rtl/feature_bucket_limiter_top.sv]
// top level of the feature bucket limiter: stream ports, config port,
// controller and datapath; depends on fbl_pkg, fbl_ctrl, fbl_datapath
`timescale 1ns / 1ps
`default_nettype none

// Feature bucket limiter. Each request is one feature point (signed Q13.4
// x and y) with a frame start flag in tuser; each point produces exactly one
// result in input order carrying its index in the frame, its grid bucket id,
// an in-image flag and a selected flag. The first max_per_bucket points of a
// bucket in a frame are selected. Points are handled one at a time, in these
// steps from one acceptance to the next when the result is taken at once
// (accept, set-up of bounds check and products, four steps of
// the restoring cell divider that yields one quotient bit per axis per cycle,
// a count memory read, and the count update). A result waiting on the output
// register stalls the update step only. Per-bucket counts sit in a 256-entry
// memory with one valid flop per entry; frame start drops all valid flags at
// once, so there is no clearing pass after reset or at a frame boundary.
// Configuration writes are taken any time but are meant for idle periods.

module feature_bucket_limiter_top (
    input  wire                            clk,
    input  wire                            rst_n,
    // configuration write port
    input  wire                            cfg_we,
    input  wire  [fbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [fbl_pkg::CFG_W-1:0]      cfg_wdata,
    // point requests
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [fbl_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // coord_x, coord_y, zero pad
    input  wire                            s_axis_tuser,  // frame_start
    // results
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [fbl_pkg::OUT_DATA_W-1:0] m_axis_tdata   // point_index, bucket_id,
                                                          // in_image, selected, zero pad
);
    import fbl_pkg::*;

    fbl_cmd_t cmd;
    fbl_sts_t sts;

    logic [INDEX_W-1:0] point_index;
    logic [ID_W-1:0]    bucket_id;
    logic               in_image;
    logic               selected;

    // sequencing
    fbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // unpack coordinates from the low bits upward
    fbl_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_x            (s_axis_tdata[COORD_W-1:0]),
        .in_y            (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .in_frame_start  (s_axis_tuser),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_point_index (point_index),
        .out_bucket_id   (bucket_id),
        .out_in_image    (in_image),
        .out_selected    (selected)
    );

    // result fields packed lowest first, padded to whole bytes
    assign m_axis_tdata = {(OUT_DATA_W - INDEX_W - ID_W - 2)'(0),
                           selected, in_image, bucket_id, point_index};

endmodule

`default_nettype wire

[hw/rtl/fbl_checker.sv]
// port-level checker of the feature bucket limiter and its bind
// depends on fbl_pkg and feature_bucket_limiter_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "feature_bucket_limiter_top_assert.svh"

module fbl_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [fbl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import fbl_pkg::*;

    logic            res_in_image;
    logic            res_selected;
    logic [ID_W-1:0] res_bucket_id;

    assign res_bucket_id = m_axis_tdata[INDEX_W+ID_W-1:INDEX_W];
    assign res_in_image  = m_axis_tdata[INDEX_W+ID_W];
    assign res_selected  = m_axis_tdata[INDEX_W+ID_W+1];

    // a pending result is not withdrawn
    `FBL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // only points inside the image can be selected
    `FBL_ASSERT_NOW(a_sel_inside, m_axis_tvalid && res_selected, res_in_image)

    // a selected point always has a bucket that is counted
    `FBL_ASSERT_NOW(a_sel_range, m_axis_tvalid && res_selected,
                    32'(res_bucket_id) < MAX_BUCKETS)

    // one point at a time: not ready again right after an accepted one
    `FBL_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind feature_bucket_limiter_top fbl_checker u_fbl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench of the feature bucket limiter top level
// depends on fbl_pkg and feature_bucket_limiter_top; holds its own predictor
`timescale 1ns / 1ps

import fbl_pkg::*;

// one result as it travels in m_axis_tdata, lowest bits last in the list
typedef struct packed {
    logic               selected;
    logic               in_image;
    logic [ID_W-1:0]    bucket_id;
    logic [INDEX_W-1:0] point_index;
} point_result_t;

// mirrors the register file and the per-bucket counts, queues the expected results
class bucket_scoreboard;
    logic [SIZE_W-1:0]  width_q;
    logic [SIZE_W-1:0]  height_q;
    logic [GRID_W-1:0]  across_q;
    logic [GRID_W-1:0]  down_q;
    logic [COUNT_W-1:0] limit_q;
    logic [COUNT_W-1:0] counts [MAX_BUCKETS];
    logic [INDEX_W-1:0] next_index;
    point_result_t      expected_q [$];
    int                 errors;
    int                 checked;
    int                 noted;

    function new();
        width_q    = RST_IMAGE_WIDTH;
        height_q   = RST_IMAGE_HEIGHT;
        across_q   = RST_BUCKETS;
        down_q     = RST_BUCKETS;
        limit_q    = RST_MAX_PER_BKT;
        next_index = '0;
        foreach (counts[i]) counts[i] = '0;
        errors  = 0;
        checked = 0;
        noted   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            REG_IMAGE_WIDTH:    width_q  = value[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:   height_q = value[SIZE_W-1:0];
            REG_BUCKETS_ACROSS: across_q = value[GRID_W-1:0];
            REG_BUCKETS_DOWN:   down_q   = value[GRID_W-1:0];
            REG_MAX_PER_BUCKET: limit_q  = value[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned grid_clamp(logic [GRID_W-1:0] v);
        if (v < 1) return 1;
        if (v > 16) return 16;
        return 32'(v);
    endfunction

    // coordinate in [0, size) in Q13.4, cell = c * cells / (size * 16)
    function bit axis_cell(int c, int unsigned size, int unsigned cells,
                           output int unsigned cell_idx);
        int unsigned lim;
        lim      = size * 16;
        cell_idx = 0;
        if (c < 0 || lim == 0 || $unsigned(c) >= lim) return 0;
        cell_idx = ($unsigned(c) * cells) / lim;
        return 1;
    endfunction

    function void note_point(logic [COORD_W-1:0] x_raw, logic [COORD_W-1:0] y_raw,
                             logic frame_start);
        int            x;
        int            y;
        int unsigned   cols;
        int unsigned   rows;
        int unsigned   col;
        int unsigned   row;
        int unsigned   id;
        bit            in_img;
        point_result_t r;
        x    = int'($signed(x_raw));
        y    = int'($signed(y_raw));
        cols = grid_clamp(across_q);
        rows = grid_clamp(down_q);
        id   = cols * rows;
        if (frame_start)
        begin
            foreach (counts[i]) counts[i] = '0;
            next_index = '0;
        end
        r.point_index = next_index;
        next_index    = next_index + 1'b1;
        in_img = axis_cell(x, 32'(width_q), cols, col);
        if (in_img)
            in_img = axis_cell(y, 32'(height_q), rows, row);
        r.selected = 1'b0;
        if (in_img)
        begin
            id = row * cols + col;
            if (id < MAX_BUCKETS && counts[id] < limit_q)
            begin
                counts[id] = counts[id] + 1'b1;
                r.selected = 1'b1;
            end
        end
        r.in_image  = in_img;
        r.bucket_id = id[ID_W-1:0];
        expected_q  = {expected_q, r};
        noted++;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // one line per mismatch, each one counted
    task report(string what, int unsigned got, int unsigned want);
        $display("mismatch on result %0d: %s got %0d, expected %0d",
                 checked, what, got, want);
        errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
        point_result_t got;
        point_result_t want;
        got = point_result_t'(data[$bits(point_result_t)-1:0]);
        if (expected_q.size() == 0)
        begin
            report("unexpected result, index", 32'(got.point_index), 0);
        end
        else
        begin
            want = expected_q.pop_front();
            if (got.point_index !== want.point_index)
                report("point_index", 32'(got.point_index), 32'(want.point_index));
            if (got.bucket_id !== want.bucket_id)
                report("bucket_id", 32'(got.bucket_id), 32'(want.bucket_id));
            if (got.in_image !== want.in_image)
                report("in_image", 32'(got.in_image), 32'(want.in_image));
            if (got.selected !== want.selected)
                report("selected", 32'(got.selected), 32'(want.selected));
        end
        checked++;
    endtask
endclass

module tb_top;

    // indexes past the last register, the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = REG_MAX_PER_BUCKET + 1'b1;

    localparam int DRAIN_CYCLES = 12;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    wire                   s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready;
    wire  [OUT_DATA_W-1:0] m_axis_tdata;

    // idle chances in percent per cycle, changed between phases
    int send_idle_pct;
    int recv_idle_pct;
    int settings_used;

    bucket_scoreboard sb;

    feature_bucket_limiter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // coord_x, coord_y, zero pad
        .s_axis_tuser  (s_axis_tuser),  // frame_start
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)   // point_index, bucket_id, in_image, selected, pad
    );

    // 20 ns clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // receiver: tready decided afresh at every falling edge
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // every result taken at a rising edge goes to the scoreboard
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    // hard stop well past the slowest correct run
    initial
    begin
        #(64'd2_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    // one point request; entered and left at a falling edge, tvalid stays high
    // on return so back-to-back requests need no extra assignment
    task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic frame_start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - 2*COORD_W){1'b0}}, y, x};
        s_axis_tuser  <= frame_start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_point(x, y, frame_start);
        @(negedge clk);
    endtask

    // stop sending and wait until every expected result is back, then let
    // the pipeline settle before any register write
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // one register write, split in steps so cfg_we gets one assignment per step
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // mostly inside the image, some right at the bounds, some anywhere
    function automatic logic [COORD_W-1:0] pick_coord(int unsigned size);
        int unsigned r;
        int          c;
        r = $urandom_range(99);
        if (r < 70 && size > 0)
            c = $urandom_range(size * 16 - 1, 0);
        else if (r < 85)
            c = int'(size * 16) + int'($urandom_range(3)) - 2;
        else
            c = $urandom();
        return c[COORD_W-1:0];
    endfunction

    // random register setting; bits above each register width are random too
    task automatic random_setting();
        logic [CFG_W-1:0] v;
        int unsigned      r;
        for (int reg_i = 0; reg_i < 2; reg_i++)
        begin
            v = CFG_W'($urandom());
            r = $urandom_range(9);
            if (r < 2)
                v[SIZE_W-1:0] = SIZE_W'($urandom_range(64, 1));
            else if (r < 3)
                v[SIZE_W-1:0] = 13'd8191;
            else if (r < 4)
                v[SIZE_W-1:0] = $urandom_range(1) ? 13'd1 : 13'd0;
            else
                v[SIZE_W-1:0] = SIZE_W'($urandom_range(8191, 1));
            set_reg(reg_i == 0 ? REG_IMAGE_WIDTH : REG_IMAGE_HEIGHT, v);
        end
        v = CFG_W'($urandom());
        set_reg(REG_BUCKETS_ACROSS, v);
        v = CFG_W'($urandom());
        set_reg(REG_BUCKETS_DOWN, v);
        r = $urandom_range(19);
        // small limits most of the time so rejection shows up often
        if (r == 0)
            v = 16'hFFFF;
        else if (r == 1)
            v = '0;
        else
            v = CFG_W'($urandom_range(6, 1));
        set_reg(REG_MAX_PER_BUCKET, v);
        settings_used++;
    endtask

    // frames of random length; the first point keeps the old counts at times,
    // so counts left above a lowered limit get exercised
    task automatic random_points(int n_points);
        int  sent;
        int  frame_len;
        bit  fs;
        sent = 0;
        while (sent < n_points)
        begin
            frame_len = $urandom_range(80, 4);
            for (int i = 0; i < frame_len && sent < n_points; i++)
            begin
                if (i == 0)
                    fs = (sent == 0) ? ($urandom_range(1) != 0) : 1'b1;
                else
                    fs = ($urandom_range(149) == 0);
                send_point(pick_coord(32'(sb.width_q)), pick_coord(32'(sb.height_q)), fs);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 57;
        settings_used = 1;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part on the reset setting: 640 x 480, 8 x 8 grid, limit 4
        send_point(18'd0, 18'd0, 1'b1);
        // same bucket until the limit rejects
        repeat (4) send_point(18'd0, 18'd0, 1'b0);
        // last pixel corner and mid image
        send_point(18'd10239, 18'd7679, 1'b0);
        send_point(18'd5119, 18'd3839, 1'b0);
        // just past each bound and just below zero
        send_point(18'd10240, 18'd0, 1'b0);
        send_point(18'd0, 18'd7680, 1'b0);
        send_point(-18'sd1, 18'd0, 1'b0);
        send_point(18'd0, -18'sd1, 1'b0);
        // coordinate extremes
        send_point(18'h20000, 18'h20000, 1'b0);
        send_point(18'h1FFFF, 18'h1FFFF, 1'b0);
        drain();

        // largest image, 16 x 16 grid, limit zero rejects everything
        set_reg(REG_IMAGE_WIDTH, 16'd8191);
        set_reg(REG_IMAGE_HEIGHT, 16'd8191);
        set_reg(REG_BUCKETS_ACROSS, 16'd16);
        set_reg(REG_BUCKETS_DOWN, 16'd16);
        set_reg(REG_MAX_PER_BUCKET, 16'd0);
        settings_used++;
        send_point(18'd131055, 18'd131055, 1'b1);
        send_point(18'd131056, 18'd0, 1'b0);
        send_point(18'd0, 18'd0, 1'b0);
        drain();

        // grid sizes out of range saturate, widest limit
        set_reg(REG_BUCKETS_ACROSS, 16'd0);
        set_reg(REG_BUCKETS_DOWN, 16'd31);
        set_reg(REG_MAX_PER_BUCKET, 16'hFFFF);
        // writes past the last register leave everything as it is
        set_reg(REG_UNUSED_LOW + CFG_IDX_W'($urandom_range(2)), CFG_W'($urandom()));
        settings_used++;
        send_point(18'd131055, 18'd131055, 1'b1);
        send_point(18'd65535, 18'd0, 1'b0);
        drain();

        // zero width, nothing is inside
        set_reg(REG_IMAGE_WIDTH, 16'd0);
        settings_used++;
        send_point(18'd0, 18'd0, 1'b1);
        drain();

        // one-pixel image, each fraction step is its own cell
        set_reg(REG_IMAGE_WIDTH, 16'd1);
        set_reg(REG_IMAGE_HEIGHT, 16'd1);
        set_reg(REG_BUCKETS_ACROSS, 16'd16);
        set_reg(REG_BUCKETS_DOWN, 16'd16);
        settings_used++;
        send_point(18'd15, 18'd15, 1'b1);
        send_point(18'd7, 18'd0, 1'b0);
        send_point(18'd16, 18'd15, 1'b0);
        drain();

        // random part: two settings per idle pattern
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 19;
                    recv_idle_pct = 57;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_idle_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            random_setting();
            random_points(115);
            drain();
        end

        $display("run covered %0d points under %0d register settings, %0d results checked",
                 sb.noted, settings_used, sb.checked);
        $display("directed corner points plus three idle patterns, %0d mismatches",
                 sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
